// ===== rtl/y2r_pkg.sv =====
package y2r_pkg;

  // Fixed-point conversion coefficients (scaled by 256).
  localparam logic signed [17:0] COEF_RV = 18'sd359;
  localparam logic signed [17:0] COEF_GU = 18'sd88;
  localparam logic signed [17:0] COEF_GV = 18'sd183;
  localparam logic signed [17:0] COEF_BU = 18'sd454;

  localparam int unsigned SUM_W = 19;

  // Per-channel chroma contributions, shared by both pixels of a pair.
  typedef struct packed {
    logic signed [17:0] r_term;
    logic signed [17:0] g_term;
    logic signed [17:0] b_term;
  } chroma_terms_t;

  // Offset-binary byte to signed chroma: U - 128 is U with its top bit flipped.
  function automatic logic signed [7:0] center_chroma(input logic [7:0] raw);
    center_chroma = {~raw[7], raw[6:0]};
  endfunction

  // Floor divide by 256, then saturate to an unsigned byte.
  function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[SUM_W-2:16]) begin
      res = 8'hFF;
    end else begin
      res = sum[15:8];
    end
    clamp_byte = res;
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] red, input logic [7:0] green,
                                          input logic [7:0] blue);
    pack565 = {red[7:3], green[7:2], blue[7:3]};
  endfunction

endpackage

// ===== rtl/y2r_if.sv =====
interface y2r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma0;
  logic [7:0] chroma_u;
  logic [7:0] luma1;
  logic [7:0] chroma_v;
  logic       frame_end;

  modport source (output valid, luma0, chroma_u, luma1, chroma_v, frame_end, input ready);
  modport sink (input valid, luma0, chroma_u, luma1, chroma_v, frame_end, output ready);
endinterface

interface y2r_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  first_blue;
  logic [7:0]  first_green;
  logic [7:0]  first_red;
  logic [7:0]  second_blue;
  logic [7:0]  second_green;
  logic [7:0]  second_red;
  logic [15:0] first_packed565;
  logic [15:0] second_packed565;
  logic        frame_end_out;

  modport source (output valid, first_blue, first_green, first_red, second_blue,
                  second_green, second_red, first_packed565, second_packed565,
                  frame_end_out, input ready);
  modport sink (input valid, first_blue, first_green, first_red, second_blue,
                second_green, second_red, first_packed565, second_packed565,
                frame_end_out, output ready);
endinterface

// ===== rtl/y2r_pixel.sv =====
module y2r_pixel
  import y2r_pkg::*;
(
  input  logic          clk,
  input  logic          en_sum,
  input  logic          en_out,
  input  logic [7:0]    luma,
  input  chroma_terms_t terms,
  output logic [7:0]    blue,
  output logic [7:0]    green,
  output logic [7:0]    red,
  output logic [15:0]   packed565
);

  logic signed [SUM_W-1:0] luma_s;
  logic signed [SUM_W-1:0] sum_r_r, sum_g_r, sum_b_r;
  logic signed [SUM_W-1:0] sum_r_nxt, sum_g_nxt, sum_b_nxt;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;
  logic [7:0]  red_r, green_r, blue_r;
  logic [15:0] pack_r;

  assign luma_s    = signed'({3'b000, luma, 8'h00});
  assign sum_r_nxt = luma_s + SUM_W'(terms.r_term);
  assign sum_g_nxt = luma_s + SUM_W'(terms.g_term);
  assign sum_b_nxt = luma_s + SUM_W'(terms.b_term);

  always_ff @(posedge clk) begin
    if (en_sum) begin
      sum_r_r <= sum_r_nxt;
      sum_g_r <= sum_g_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

  assign red_nxt   = clamp_byte(sum_r_r);
  assign green_nxt = clamp_byte(sum_g_r);
  assign blue_nxt  = clamp_byte(sum_b_r);

  always_ff @(posedge clk) begin
    if (en_out) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      pack_r  <= pack565(red_nxt, green_nxt, blue_nxt);
    end
  end

  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign packed565 = pack_r;

endmodule

// ===== rtl/yuyv_to_rgb888_rgb565_unit.sv =====
// YUYV 4:2:2 to RGB888/RGB565 converter. Each input transaction carries one
// macro-pixel (Y0, U, Y1, V) plus an end-of-frame flag, and yields exactly one
// output transaction with both pixels as clamped 8-bit R, G, B and as packed
// RGB565, with the flag copied through. The block sustains one transaction per
// clock while the output is not stalled, through three register stages. Each
// result moves through the stage registers in order and shows as output valid
// once it reaches the third. The first stage forms the chroma products, the
// second adds luma, and the third clamps, packs and holds the result in the
// output register. Each stage advances when it is empty or its successor
// advances, so bubbles are squeezed out. While a finished result waits on a
// stalled output, input is still taken as long as an earlier stage is empty;
// once all three stages are full, input ready drops in the same cycle as the
// output stall, because ready is a combinational function of the output ready.
// There is no configuration and no state between items.
module yuyv_to_rgb888_rgb565_unit
  import y2r_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  y2r_in_if.sink     in_ch,
  y2r_out_if.source  out_ch
);

  // Stage valid bits travel alongside the data.
  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic en1, en2, en3;

  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;

  assign v1_nxt = en1 ? in_ch.valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign v3_nxt = en3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Stage 1: centered chroma times the fixed coefficients. These terms are
  // shared by both pixels of the pair; green gets both contributions negated.
  logic signed [7:0]  u_c, v_c;
  logic signed [17:0] u_w, v_w;
  chroma_terms_t      terms_nxt, terms_r;
  logic [7:0]         luma0_r, luma1_r;
  logic               fe1_r, fe2_r, fe3_r;

  assign u_c = center_chroma(in_ch.chroma_u);
  assign v_c = center_chroma(in_ch.chroma_v);
  assign u_w = 18'(u_c);
  assign v_w = 18'(v_c);

  assign terms_nxt.r_term = COEF_RV * v_w;
  assign terms_nxt.g_term = -(COEF_GU * u_w) - (COEF_GV * v_w);
  assign terms_nxt.b_term = COEF_BU * u_w;

  always_ff @(posedge clk) begin
    if (en1) begin
      terms_r <= terms_nxt;
      luma0_r <= in_ch.luma0;
      luma1_r <= in_ch.luma1;
      fe1_r   <= in_ch.frame_end;
    end
    if (en2) begin
      fe2_r <= fe1_r;
    end
    if (en3) begin
      fe3_r <= fe2_r;
    end
  end

  // Stages 2 and 3 live in the per-pixel datapath.
  y2r_pixel u_pix0 (
    .clk       (clk),
    .en_sum    (en2),
    .en_out    (en3),
    .luma      (luma0_r),
    .terms     (terms_r),
    .blue      (out_ch.first_blue),
    .green     (out_ch.first_green),
    .red       (out_ch.first_red),
    .packed565 (out_ch.first_packed565)
  );

  y2r_pixel u_pix1 (
    .clk       (clk),
    .en_sum    (en2),
    .en_out    (en3),
    .luma      (luma1_r),
    .terms     (terms_r),
    .blue      (out_ch.second_blue),
    .green     (out_ch.second_green),
    .red       (out_ch.second_red),
    .packed565 (out_ch.second_packed565)
  );

  assign out_ch.valid         = v3_r;
  assign out_ch.frame_end_out = fe3_r;

`ifndef NO_ASSERTIONS
  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !v1_r && !v2_r && !v3_r)
    else $error("pipeline not empty after reset");

  // An empty first stage must always be able to take a transaction.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_ch.ready)
    else $error("input stalled with empty first stage");

  // A stalled first stage keeps its chroma terms.
  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !en2 |=> v1_r && $stable(terms_r))
    else $error("stage 1 lost data under stall");

  // Packed output agrees with the byte outputs for first-pixel red and second-pixel green.
  a_pack_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.first_packed565[15:11] == out_ch.first_red[7:3] &&
                     out_ch.second_packed565[10:5] == out_ch.second_green[7:2])
    else $error("RGB565 packing mismatch");
`endif

endmodule
